// ----- rtl/complex_arithmetic_unit_defines.svh -----
// Assertion macros shared by the complex arithmetic unit RTL.
`ifndef COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define CAU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition is followed in the next cycle by another.
`define CAU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/cau_pkg.sv -----
// Types and codes of the complex arithmetic unit.
package cau_pkg;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DIV0 = 2'd1,
    ST_SAT  = 2'd2
  } status_e;

  typedef struct packed {
    cmd_e               command;
    logic signed [31:0] a_real;
    logic signed [31:0] a_imag;
    logic signed [31:0] b_real;
    logic signed [31:0] b_imag;
  } cau_in_t;

  typedef struct packed {
    logic signed [31:0] res_real;
    logic signed [31:0] res_imag;
    logic [1:0]         status;
  } cau_out_t;

endpackage

// ----- rtl/complex_arithmetic_unit.sv -----
// Complex arithmetic unit: add, subtract, multiply and divide in signed fixed point.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+----------------------------
//  in      | input     | in_valid_i / in_ready_o  | in_data_i  (cau_in_t)
//  out     | output    | out_valid_o / out_ready_i| out_data_o (cau_out_t)
//
// One transaction enters per cycle while in_ready_o is high; the restoring divider
// resolves one quotient bit per stage. Every command runs through the same stages,
// so order is kept.
// Reset clears only the valid bits and the skid flag; payload registers are free.
// A stalled output holds the result in the output register; one more result
// lands in a skid register, and only then does in_ready_o drop.
`include "complex_arithmetic_unit_defines.svh"

module complex_arithmetic_unit import cau_pkg::*; #(
  parameter int DATA_WIDTH    = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  cau_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output cau_out_t out_data_o
);

  localparam int DW = DATA_WIDTH;
  localparam int FB = FRACTION_BITS;
  localparam int P  = 2 * DW;          // full product width
  localparam int QW = DW + 1;          // quotient bits kept before capping
  localparam int W  = P + FB + QW;     // divider remainder width
  localparam int ND = QW + 2;          // divider stages incl. set-up and range check
  localparam int NV = 3 + ND;          // pipeline stages ahead of the output register

  localparam logic [P-1:0]  CAP  = P'(1) << DW;
  localparam logic [P-1:0]  HALF = P'(1) << (DW - 1);
  localparam logic [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};

  typedef struct packed {
    cmd_e                 cmd;
    logic signed [DW-1:0] ar;
    logic signed [DW-1:0] ai;
    logic signed [DW-1:0] br;
    logic signed [DW-1:0] bi;
  } s0_t;

  typedef struct packed {
    cmd_e                cmd;
    logic signed [P-1:0] m_rr;
    logic signed [P-1:0] m_ii;
    logic signed [P-1:0] m_ri;
    logic signed [P-1:0] m_ir;
    logic [P-1:0]        sq_r;
    logic [P-1:0]        sq_i;
    logic signed [DW:0]  as_r;
    logic signed [DW:0]  as_i;
  } s1_t;

  typedef struct packed {
    cmd_e              cmd;
    logic signed [P:0] nr;
    logic signed [P:0] ni;
    logic [P-1:0]      den;
  } s2_t;

  // Divider stage: bypassed for add, subtract and multiply, whose magnitude rides in rem.
  typedef struct packed {
    logic          byp;
    logic          dz;
    logic          neg_r;
    logic          neg_i;
    logic          ovf_r;
    logic          ovf_i;
    logic [P-1:0]  den;
    logic [W-1:0]  rem_r;
    logic [W-1:0]  rem_i;
    logic [QW-1:0] q_r;
    logic [QW-1:0] q_i;
  } dv_t;

  logic          en;
  logic [NV-1:0] vld_q, vld_d;
  s0_t           s0_q, s0_d;
  s1_t           s1_q, s1_d;
  s2_t           s2_q, s2_d;
  dv_t           dv_q [ND];
  dv_t           dv_d [ND];
  cau_out_t      res;
  cau_out_t      out_q, out_d, skid_q, skid_d;
  logic          out_v_q, out_v_d, skid_v_q, skid_v_d;

  // The whole pipeline advances together; only a full skid register halts it.
  assign en         = !skid_v_q;
  assign in_ready_o = en;

  assign vld_d = {vld_q[NV-2:0], in_valid_i};

  // Stage 0: capture, keep the low DATA_WIDTH bits of each part.
  always_comb begin
    s0_d.cmd = in_data_i.command;
    s0_d.ar  = in_data_i.a_real[DW-1:0];
    s0_d.ai  = in_data_i.a_imag[DW-1:0];
    s0_d.br  = in_data_i.b_real[DW-1:0];
    s0_d.bi  = in_data_i.b_imag[DW-1:0];
  end

  // Stage 1: full-width products and squares, plus the add/subtract result.
  always_comb begin
    s1_d.cmd  = s0_q.cmd;
    s1_d.m_rr = s0_q.ar * s0_q.br;
    s1_d.m_ii = s0_q.ai * s0_q.bi;
    s1_d.m_ri = s0_q.ar * s0_q.bi;
    s1_d.m_ir = s0_q.ai * s0_q.br;
    s1_d.sq_r = s0_q.br * s0_q.br;
    s1_d.sq_i = s0_q.bi * s0_q.bi;
    if (s0_q.cmd == CMD_SUB) begin
      s1_d.as_r = s0_q.ar - s0_q.br;
      s1_d.as_i = s0_q.ai - s0_q.bi;
    end else begin
      s1_d.as_r = s0_q.ar + s0_q.br;
      s1_d.as_i = s0_q.ai + s0_q.bi;
    end
  end

  // Stage 2: form the real and imaginary numerators and the divide denominator.
  always_comb begin
    s2_d.cmd = s1_q.cmd;
    s2_d.den = s1_q.sq_r + s1_q.sq_i;
    unique case (s1_q.cmd) inside
      CMD_ADD, CMD_SUB: begin
        s2_d.nr = (P+1)'(s1_q.as_r);
        s2_d.ni = (P+1)'(s1_q.as_i);
      end
      CMD_MUL: begin
        s2_d.nr = s1_q.m_rr - s1_q.m_ii;
        s2_d.ni = s1_q.m_ri + s1_q.m_ir;
      end
      default: begin
        s2_d.nr = s1_q.m_rr + s1_q.m_ii;
        s2_d.ni = s1_q.m_ir - s1_q.m_ri;
      end
    endcase
  end

  // Divider set-up: sign and magnitude, scale the product, load the dividend.
  always_comb begin
    logic [P:0]   abs_r, abs_i;
    logic [P-1:0] mag_r, mag_i;
    abs_r = s2_q.nr[P] ? (P+1)'(-s2_q.nr) : (P+1)'(s2_q.nr);
    abs_i = s2_q.ni[P] ? (P+1)'(-s2_q.ni) : (P+1)'(s2_q.ni);
    mag_r = abs_r[P-1:0];
    mag_i = abs_i[P-1:0];
    if (s2_q.cmd == CMD_MUL) begin
      mag_r = mag_r >> FB;
      mag_i = mag_i >> FB;
    end
    dv_d[0].byp   = (s2_q.cmd != CMD_DIV);
    dv_d[0].dz    = (s2_q.cmd == CMD_DIV) && (s2_q.den == '0);
    dv_d[0].neg_r = s2_q.nr[P];
    dv_d[0].neg_i = s2_q.ni[P];
    dv_d[0].ovf_r = 1'b0;
    dv_d[0].ovf_i = 1'b0;
    dv_d[0].den   = s2_q.den;
    dv_d[0].q_r   = '0;
    dv_d[0].q_i   = '0;
    if (s2_q.cmd == CMD_DIV) begin
      dv_d[0].rem_r = W'(mag_r) << FB;
      dv_d[0].rem_i = W'(mag_i) << FB;
    end else begin
      dv_d[0].rem_r = W'(mag_r);
      dv_d[0].rem_i = W'(mag_i);
    end
  end

  // Range check: a quotient of 2^(DATA_WIDTH+1) or more is capped.
  always_comb begin
    dv_d[1] = dv_q[0];
    if (!dv_q[0].byp) begin
      dv_d[1].ovf_r = dv_q[0].rem_r >= (W'(dv_q[0].den) << QW);
      dv_d[1].ovf_i = dv_q[0].rem_i >= (W'(dv_q[0].den) << QW);
    end
  end

  // Restoring division: one quotient bit per stage, most significant first.
  for (genvar j = 2; j < ND; j++) begin : g_div
    localparam int B = ND - 1 - j;
    always_comb begin
      logic [W:0] t_r, t_i;
      t_r = {1'b0, dv_q[j-1].rem_r} - {1'b0, W'(dv_q[j-1].den) << B};
      t_i = {1'b0, dv_q[j-1].rem_i} - {1'b0, W'(dv_q[j-1].den) << B};
      dv_d[j] = dv_q[j-1];
      if (!dv_q[j-1].byp && !dv_q[j-1].ovf_r && !t_r[W]) begin
        dv_d[j].rem_r = t_r[W-1:0];
        dv_d[j].q_r[B] = 1'b1;
      end
      if (!dv_q[j-1].byp && !dv_q[j-1].ovf_i && !t_i[W]) begin
        dv_d[j].rem_i = t_i[W-1:0];
        dv_d[j].q_i[B] = 1'b1;
      end
    end
  end

  // Saturate each part to the signed range and pick the status.
  always_comb begin
    dv_t          f;
    logic [P-1:0] v_r, v_i;
    logic         sat_r, sat_i;
    logic [DW-1:0] r_r, r_i;
    f     = dv_q[ND-1];
    v_r   = f.byp ? f.rem_r[P-1:0] : (f.ovf_r ? CAP : P'(f.q_r));
    v_i   = f.byp ? f.rem_i[P-1:0] : (f.ovf_i ? CAP : P'(f.q_i));
    sat_r = f.neg_r ? (v_r > HALF) : (v_r >= HALF);
    sat_i = f.neg_i ? (v_i > HALF) : (v_i >= HALF);
    r_r   = sat_r ? (f.neg_r ? MINV : MAXV) : (f.neg_r ? -v_r[DW-1:0] : v_r[DW-1:0]);
    r_i   = sat_i ? (f.neg_i ? MINV : MAXV) : (f.neg_i ? -v_i[DW-1:0] : v_i[DW-1:0]);
    if (f.dz) begin
      res.res_real = '0;
      res.res_imag = '0;
      res.status   = ST_DIV0;
    end else begin
      res.res_real = 32'($signed(r_r));
      res.res_imag = 32'($signed(r_i));
      res.status   = (sat_r || sat_i) ? ST_SAT : ST_OK;
    end
  end

  // Output register with a one-deep skid behind it.
  always_comb begin
    logic out_free;
    out_free = !out_v_q || out_ready_i;
    out_d    = out_q;
    skid_d   = skid_q;
    out_v_d  = out_v_q && !out_ready_i;
    skid_v_d = skid_v_q;
    if (skid_v_q) begin
      if (out_free) begin
        out_d    = skid_q;
        out_v_d  = 1'b1;
        skid_v_d = 1'b0;
      end
    end else if (vld_q[NV-1]) begin
      if (out_free) begin
        out_d   = res;
        out_v_d = 1'b1;
      end else begin
        skid_d   = res;
        skid_v_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (en) begin
        vld_q <= vld_d;
      end
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_q <= s0_d;
      s1_q <= s1_d;
      s2_q <= s2_d;
      for (int k = 0; k < ND; k++) begin
        dv_q[k] <= dv_d[k];
      end
    end
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  // Hold: the skid only fills behind a waiting result.
  `CAU_ASSERT(a_skid_behind_out, skid_v_q |-> out_v_q, "skid full with empty output")
  // Hold: a parked result stays parked until the output drains.
  `CAU_ASSERT_NEXT(a_skid_holds, skid_v_q && !out_ready_i, skid_v_q, "skid result lost")
  // A zero divisor always reports a zero result.
  `CAU_ASSERT(a_div0_zero, out_v_q && out_q.status == ST_DIV0 |-> out_q.res_real == '0 && out_q.res_imag == '0, "divide by zero with non-zero result")

endmodule
